FILE: src/htwd_pkg.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder package
// Shared widths, register map and controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package htwd_pkg;

   // Width of a node index on the ports and in the node table.
   localparam int IDX_W = 9;

   // Width of a code byte and of the emitted symbol port.
   localparam int BYTE_W = 8;

   // Width of the valid-bit count and its saturation value.
   localparam int CNT_W    = 4;
   localparam int CNT_MAX  = 8;

   // Configuration register map (word index taken from the byte address).
   localparam int  CSR_ADDR_W  = 3;
   localparam logic CSR_ROOT_IDX = 1'b0;

   // Input transaction kinds.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_CODE = 1'b1;

   // Walk controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_FETCH,
      ST_CHILD,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

FILE: src/huffman_tree_walk_decoder_core.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder core
// Walks a binary code tree held in a node table, one code bit per step, and
// emits the symbol of every leaf it reaches.
//
//   Channel  Direction  Handshake              Contents
//   req_     in         req_valid / req_stall  node load or code byte
//   rsp_     out        rsp_valid / rsp_stall  symbol, last_of_run
//   csr_     in/out     APB, pready always 1   root_node at word 0
//
// The block stalls new requests until a code byte is walked in full. Each
// code bit is one node-table read followed by a leaf test, and each fetch of
// the entry the walk stands on, needed after every leaf and after a load or a
// root write, costs one extra read through the single RAM read port. The node
// table has no reset; reset clears only the walk state and the root register.
// A stalled result holds the walk at its next leaf or at the end of the byte.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_walk_decoder_core #(
   parameter int NODE_COUNT  = 512,
   parameter int SYMBOL_BITS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_kind,
   input  wire logic [htwd_pkg::IDX_W-1:0]        req_node_index,
   input  wire logic [htwd_pkg::IDX_W-1:0]        req_left_child,
   input  wire logic [htwd_pkg::IDX_W-1:0]        req_right_child,
   input  wire logic                              req_is_leaf,
   input  wire logic [htwd_pkg::BYTE_W-1:0]       req_leaf_symbol,
   input  wire logic [htwd_pkg::BYTE_W-1:0]       req_code_byte,
   input  wire logic [htwd_pkg::CNT_W-1:0]        req_valid_bits,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [htwd_pkg::BYTE_W-1:0]       rsp_symbol,
   output logic                                   rsp_last_of_run,

   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [htwd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic      [31:0]                       csr_prdata,
   output logic                                   csr_pready
);

   localparam int IW = htwd_pkg::IDX_W;
   localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int EW = 2 * IW + 1 + SYMBOL_BITS;
   localparam int BW = htwd_pkg::BYTE_W;
   localparam int CW = htwd_pkg::CNT_W;

   // Node entry layout: {left, right, leaf, symbol}.
   localparam int LEFT_LSB  = IW + 1 + SYMBOL_BITS;
   localparam int RIGHT_LSB = 1 + SYMBOL_BITS;
   localparam int LEAF_BIT  = SYMBOL_BITS;

   htwd_pkg::state_type state_ff, state_in;

   logic [IW-1:0]          root_ff, root_in;
   logic [IW-1:0]          cur_node_ff, cur_node_in;
   logic [IW-1:0]          cur_left_ff, cur_left_in;
   logic [IW-1:0]          cur_right_ff, cur_right_in;
   logic                   cur_ok_ff, cur_ok_in;
   logic [IW-1:0]          child_ff, child_in;
   logic                   rd_oob_ff, rd_oob_in;
   logic [BW-1:0]          bits_ff, bits_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [SYMBOL_BITS-1:0] pend_sym_ff, pend_sym_in;
   logic                   out_valid_ff, out_valid_in;
   logic [BW-1:0]          out_sym_ff, out_sym_in;
   logic                   out_last_ff, out_last_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [EW-1:0]          ram_wdata;
   logic                   ram_re;
   logic [AW-1:0]          ram_raddr;
   logic [EW-1:0]          ram_rdata;
   logic [EW-1:0]          rd_entry;

   logic                   req_accept;
   logic                   csr_write;
   logic                   out_free;
   logic                   rd_leaf;
   logic [IW-1:0]          walk_child;
   logic [CW-1:0]          sat_cnt;

   // Node table storage.
   htwd_ram #(
      .WIDTH (EW),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Handshake and shared decode.
   assign req_stall  = (state_ff != htwd_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free   = !out_valid_ff || !rsp_stall;

   // An entry beyond the table reads as an all-zero, non-leaf node.
   assign rd_entry   = rd_oob_ff ? '0 : ram_rdata;
   assign rd_leaf    = rd_entry[LEAF_BIT];
   assign walk_child = bits_ff[BW-1] ? cur_right_ff : cur_left_ff;
   assign sat_cnt    = (req_valid_bits > CW'(htwd_pkg::CNT_MAX)) ?
                       CW'(htwd_pkg::CNT_MAX) : req_valid_bits;

   // Configuration port.
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[htwd_pkg::CSR_ADDR_W-1] == htwd_pkg::CSR_ROOT_IDX) begin
         csr_prdata = 32'(root_ff);
      end
   end

   // Next-state logic of the walk controller.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         htwd_pkg::ST_IDLE: begin
            if (req_accept && req_kind == htwd_pkg::KIND_CODE && sat_cnt != '0) begin
               state_in = htwd_pkg::ST_WALK;
            end
         end
         htwd_pkg::ST_WALK: begin
            if (cnt_ff == '0) begin
               state_in = htwd_pkg::ST_FLUSH;
            end else if (!cur_ok_ff) begin
               state_in = htwd_pkg::ST_FETCH;
            end else begin
               state_in = htwd_pkg::ST_CHILD;
            end
         end
         htwd_pkg::ST_FETCH: begin
            state_in = htwd_pkg::ST_WALK;
         end
         htwd_pkg::ST_CHILD: begin
            if (!rd_leaf || !pend_valid_ff || out_free) begin
               state_in = htwd_pkg::ST_WALK;
            end
         end
         htwd_pkg::ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = htwd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = htwd_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and memory controls for each state.
   always_comb begin
      root_in       = root_ff;
      cur_node_in   = cur_node_ff;
      cur_left_in   = cur_left_ff;
      cur_right_in  = cur_right_ff;
      cur_ok_in     = cur_ok_ff;
      child_in      = child_ff;
      rd_oob_in     = rd_oob_ff;
      bits_in       = bits_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_sym_in    = out_sym_ff;
      out_last_in   = out_last_ff;

      ram_we    = 1'b0;
      ram_waddr = AW'(req_node_index);
      ram_wdata = {req_left_child, req_right_child, req_is_leaf,
                   SYMBOL_BITS'(req_leaf_symbol)};
      ram_re    = 1'b0;
      ram_raddr = AW'(cur_node_ff);

      unique case (state_ff)
         htwd_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_kind == htwd_pkg::KIND_LOAD) begin
                  // A load may overwrite the cached current entry.
                  ram_we    = (32'(req_node_index) < NODE_COUNT);
                  cur_ok_in = 1'b0;
               end else begin
                  bits_in = req_code_byte;
                  cnt_in  = sat_cnt;
               end
            end
         end
         htwd_pkg::ST_WALK: begin
            if (cnt_ff != '0) begin
               if (!cur_ok_ff) begin
                  // Fetch the children of the node the walk stands on.
                  ram_re    = 1'b1;
                  ram_raddr = AW'(cur_node_ff);
                  rd_oob_in = !(32'(cur_node_ff) < NODE_COUNT);
               end else begin
                  // Take one code bit and read the chosen child.
                  ram_re    = 1'b1;
                  ram_raddr = AW'(walk_child);
                  rd_oob_in = !(32'(walk_child) < NODE_COUNT);
                  child_in  = walk_child;
                  bits_in   = {bits_ff[BW-2:0], 1'b0};
                  cnt_in    = cnt_ff - CW'(1);
               end
            end
         end
         htwd_pkg::ST_FETCH: begin
            cur_left_in  = rd_entry[LEFT_LSB +: IW];
            cur_right_in = rd_entry[RIGHT_LSB +: IW];
            cur_ok_in    = 1'b1;
         end
         htwd_pkg::ST_CHILD: begin
            if (!rd_leaf) begin
               // Inner node: its entry becomes the current one.
               cur_node_in  = child_ff;
               cur_left_in  = rd_entry[LEFT_LSB +: IW];
               cur_right_in = rd_entry[RIGHT_LSB +: IW];
               cur_ok_in    = 1'b1;
            end else if (!pend_valid_ff || out_free) begin
               // Leaf: release the older symbol, hold this one, back to root.
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_sym_in   = BW'(pend_sym_ff);
                  out_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_sym_in   = rd_entry[SYMBOL_BITS-1:0];
               cur_node_in   = root_ff;
               cur_ok_in     = 1'b0;
            end
         end
         htwd_pkg::ST_FLUSH: begin
            // The held symbol is the last one of this code byte.
            if (pend_valid_ff && out_free) begin
               out_valid_in  = 1'b1;
               out_sym_in    = BW'(pend_sym_ff);
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
            cur_ok_in = 1'b0;
         end
      endcase

      // A root write restarts the walk at the new root.
      if (csr_write &&
          csr_paddr[htwd_pkg::CSR_ADDR_W-1] == htwd_pkg::CSR_ROOT_IDX) begin
         root_in     = csr_pwdata[IW-1:0];
         cur_node_in = csr_pwdata[IW-1:0];
         cur_ok_in   = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= htwd_pkg::ST_IDLE;
         root_ff       <= '0;
         cur_node_ff   <= '0;
         cur_ok_ff     <= 1'b0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         root_ff       <= root_in;
         cur_node_ff   <= cur_node_in;
         cur_ok_ff     <= cur_ok_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_left_ff  <= cur_left_in;
      cur_right_ff <= cur_right_in;
      child_ff     <= child_in;
      rd_oob_ff    <= rd_oob_in;
      bits_ff      <= bits_in;
      pend_sym_ff  <= pend_sym_in;
      out_sym_ff   <= out_sym_in;
      out_last_ff  <= out_last_in;
   end

   // Result channel.
   assign rsp_valid       = out_valid_ff;
   assign rsp_symbol      = out_sym_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

`default_nettype wire

FILE: src/htwd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with a registered read that holds its
// data while no read is requested.
// ----------------------------------------------------------------------------
`default_nettype none

module htwd_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: dv/huffman_tree_walk_decoder_core_test.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder core testbench
// Loads code trees into the node table, moves the root register and feeds code
// bytes. A built-in copy of the tree walk predicts each decoded symbol unless a
// directed row carries its own expectation, and each result transaction is
// checked in order. A short directed table covers the corner cases. Random code
// trees follow, built bottom-up so the walk only ever reads nodes that were loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_walk_decoder_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_W      = htwd_pkg::IDX_W;
   localparam int BYTE_W     = htwd_pkg::BYTE_W;
   localparam int CNT_W      = htwd_pkg::CNT_W;
   localparam int CNT_MAX    = htwd_pkg::CNT_MAX;
   localparam int CSR_ADDR_W = htwd_pkg::CSR_ADDR_W;

   localparam int CLK_PERIOD   = 8;
   localparam int NODE_COUNT   = 512;
   localparam int SETTLE       = 40;      // long enough for a full byte with eight leaves
   localparam int CYCLE_LIMIT  = 200000;
   localparam int TREE_COUNT   = 6;
   localparam int STREAM_ITEMS = 36;
   localparam logic [CSR_ADDR_W-1:0] ROOT_ADDR = {htwd_pkg::CSR_ROOT_IDX, 2'b00};

   // One request transaction: a node load or a code byte.
   typedef struct packed {
      logic              kind;
      logic [IDX_W-1:0]  node_index;
      logic [IDX_W-1:0]  left;
      logic [IDX_W-1:0]  right;
      logic              leaf;
      logic [BYTE_W-1:0] sym;
      logic [BYTE_W-1:0] code;
      logic [CNT_W-1:0]  bits;
   } decoder_item_type;

   // One decoded symbol as it leaves the block.
   typedef struct packed {
      logic [BYTE_W-1:0] symbol;
      logic              last;
   } symbol_rsp_type;

   typedef enum logic [1:0] {ROW_LOAD, ROW_CODE, ROW_ROOT} row_op_type;

   // Directed row. Where typed is set, the row carries its own expectation:
   // one symbol with last_of_run when hit is set, no result otherwise.
   typedef struct packed {
      row_op_type        op;
      logic [IDX_W-1:0]  index;
      logic [IDX_W-1:0]  left;
      logic [IDX_W-1:0]  right;
      logic              leaf;
      logic [BYTE_W-1:0] sym;
      logic [BYTE_W-1:0] code;
      logic [CNT_W-1:0]  bits;
      logic              typed;
      logic              hit;
      logic [BYTE_W-1:0] want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic                  req_kind        = htwd_pkg::KIND_LOAD;
   logic [IDX_W-1:0]      req_node_index  = '0;
   logic [IDX_W-1:0]      req_left_child  = '0;
   logic [IDX_W-1:0]      req_right_child = '0;
   logic                  req_is_leaf     = 1'b0;
   logic [BYTE_W-1:0]     req_leaf_symbol = '0;
   logic [BYTE_W-1:0]     req_code_byte   = '0;
   logic [CNT_W-1:0]      req_valid_bits  = '0;

   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [BYTE_W-1:0]     rsp_symbol;
   logic                  rsp_last_of_run;

   logic                  csr_psel        = 1'b0;
   logic                  csr_penable     = 1'b0;
   logic                  csr_pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr       = '0;
   logic [31:0]           csr_pwdata      = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Idle pattern of both sides, and a hold that keeps the receiver ready.
   int   gap_pct   = 0;
   int   stall_pct = 0;
   logic hold_rsp  = 1'b0;

   int errors       = 0;
   int items_sent   = 0;
   int symbols_seen = 0;
   int trees_built  = 0;
   int root_writes  = 0;
   int cycle_count  = 0;

   // Predicted decoder state.
   logic [IDX_W-1:0]  node_left   [NODE_COUNT];
   logic [IDX_W-1:0]  node_right  [NODE_COUNT];
   logic              node_leaf   [NODE_COUNT];
   logic [BYTE_W-1:0] node_sym    [NODE_COUNT];
   bit                node_loaded [NODE_COUNT];
   int                loaded_nodes[$];
   logic [IDX_W-1:0]  root_idx  = '0;
   logic [IDX_W-1:0]  walk_node = '0;

   symbol_rsp_type decoded [CNT_MAX];
   int             decoded_n;
   symbol_rsp_type expected_symbols[$];
   bit             in_tree [NODE_COUNT];

   plan_row_type plan [24] = '{
      '{ROW_LOAD, 9'd511, 9'd511, 9'd511, 1'b1, 8'hFF, 8'h00, 4'd0,  1'b1, 1'b0, 8'h00},
      '{ROW_LOAD, 9'd2,   9'd0,   9'd0,   1'b1, 8'h00, 8'h00, 4'd0,  1'b1, 1'b0, 8'h00},
      '{ROW_LOAD, 9'd3,   9'h155, 9'h0AA, 1'b1, 8'hA5, 8'h00, 4'd0,  1'b1, 1'b0, 8'h00},
      '{ROW_LOAD, 9'd1,   9'd2,   9'd3,   1'b0, 8'h5A, 8'h00, 4'd0,  1'b1, 1'b0, 8'h00},
      '{ROW_LOAD, 9'd0,   9'd511, 9'd1,   1'b0, 8'h00, 8'h00, 4'd0,  1'b1, 1'b0, 8'h00},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'h00, 4'd0,  1'b1, 1'b0, 8'h00},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'h00, 4'd1,  1'b1, 1'b1, 8'hFF},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'h80, 4'd1,  1'b1, 1'b0, 8'h00},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'h00, 4'd1,  1'b1, 1'b1, 8'h00},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'hFF, 4'd8,  1'b0, 1'b0, 8'h00},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'h00, 4'd15, 1'b0, 1'b0, 8'h00},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'hC0, 4'd2,  1'b1, 1'b1, 8'hA5},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'h55, 4'd9,  1'b0, 1'b0, 8'h00},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'h80, 4'd1,  1'b1, 1'b1, 8'hA5},
      '{ROW_ROOT, 9'd511, 9'd0,   9'd0,   1'b0, 8'h00, 8'h00, 4'd0,  1'b0, 1'b0, 8'h00},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'h00, 4'd2,  1'b0, 1'b0, 8'h00},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'hFF, 4'd1,  1'b1, 1'b1, 8'hFF},
      '{ROW_ROOT, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'h00, 4'd0,  1'b0, 1'b0, 8'h00},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'h80, 4'd1,  1'b1, 1'b0, 8'h00},
      '{ROW_ROOT, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'h00, 4'd0,  1'b0, 1'b0, 8'h00},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'h00, 4'd1,  1'b1, 1'b1, 8'hFF},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'h80, 4'd1,  1'b1, 1'b0, 8'h00},
      '{ROW_LOAD, 9'd1,   9'd3,   9'd2,   1'b0, 8'hC3, 8'h00, 4'd0,  1'b1, 1'b0, 8'h00},
      '{ROW_CODE, 9'd0,   9'd0,   9'd0,   1'b0, 8'h00, 8'h00, 4'd1,  1'b1, 1'b1, 8'hA5}
   };

   huffman_tree_walk_decoder_core #(
      .NODE_COUNT  (NODE_COUNT),
      .SYMBOL_BITS (BYTE_W)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_node_index  (req_node_index),
      .req_left_child  (req_left_child),
      .req_right_child (req_right_child),
      .req_is_leaf     (req_is_leaf),
      .req_leaf_symbol (req_leaf_symbol),
      .req_code_byte   (req_code_byte),
      .req_valid_bits  (req_valid_bits),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_symbol      (rsp_symbol),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("huffman_tree_walk_decoder_core test failed");
         $finish;
      end
   end

   // Receiver stalls at random unless it is held ready.
   always @(posedge clock) begin
      rsp_stall <= !hold_rsp && ($urandom_range(99) < stall_pct);
   end

   // Compare every accepted result transaction with the oldest prediction.
   always @(posedge clock) begin
      symbol_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_symbols.size() == 0) begin
            $error("unexpected result: symbol %0h, last_of_run %0b",
                   rsp_symbol, rsp_last_of_run);
            errors++;
         end else begin
            want = expected_symbols.pop_front();
            symbols_seen++;
            if (rsp_symbol !== want.symbol) begin
               $error("symbol: expected %0h, actual %0h", want.symbol, rsp_symbol);
               errors++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0b, actual %0b", want.last, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   // Tree walk of one accepted item. Loads update the node table; code bytes
   // leave their symbols in decoded[0 .. decoded_n-1].
   function automatic void decode_item(decoder_item_type it);
      int               count;
      int               k;
      logic             bit_val;
      logic [IDX_W-1:0] nxt;
      decoded_n = 0;
      if (it.kind == htwd_pkg::KIND_LOAD) begin
         node_left[it.node_index]  = it.left;
         node_right[it.node_index] = it.right;
         node_leaf[it.node_index]  = it.leaf;
         node_sym[it.node_index]   = it.sym;
         if (!node_loaded[it.node_index]) begin
            node_loaded[it.node_index] = 1'b1;
            loaded_nodes.push_back(int'(it.node_index));
         end
         return;
      end
      count = (it.bits > CNT_MAX) ? CNT_MAX : int'(it.bits);
      for (k = 0; k < count; k++) begin
         bit_val = it.code[BYTE_W-1-k];
         nxt = bit_val ? node_right[walk_node] : node_left[walk_node];
         // A leaf emits its symbol and sends the walk back to the root.
         if (node_leaf[nxt]) begin
            decoded[decoded_n] = '{node_sym[nxt], 1'b0};
            decoded_n++;
            walk_node = root_idx;
         end else begin
            walk_node = nxt;
         end
      end
      if (decoded_n > 0) decoded[decoded_n-1].last = 1'b1;
   endfunction

   function automatic decoder_item_type random_item();
      decoder_item_type it;
      it.kind       = 1'($urandom_range(1));
      it.node_index = IDX_W'($urandom_range(NODE_COUNT - 1));
      it.left       = IDX_W'($urandom_range(NODE_COUNT - 1));
      it.right      = IDX_W'($urandom_range(NODE_COUNT - 1));
      it.leaf       = 1'($urandom_range(1));
      it.sym        = BYTE_W'($urandom_range(255));
      it.code       = BYTE_W'($urandom_range(255));
      it.bits       = CNT_W'($urandom_range(15));
      return it;
   endfunction

   // Node index not yet used by the tree under construction.
   function automatic logic [IDX_W-1:0] fresh_index();
      int idx;
      idx = $urandom_range(NODE_COUNT - 1);
      while (in_tree[idx]) idx = $urandom_range(NODE_COUNT - 1);
      in_tree[idx] = 1'b1;
      return IDX_W'(idx);
   endfunction

   // Offer one request transaction, after a random sender gap, and record
   // its expected symbols once it is accepted.
   task automatic send_item(input decoder_item_type it, input logic typed, input logic hit,
                            input logic [BYTE_W-1:0] want);
      int k;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= it.kind;
      req_node_index  <= it.node_index;
      req_left_child  <= it.left;
      req_right_child <= it.right;
      req_is_leaf     <= it.leaf;
      req_leaf_symbol <= it.sym;
      req_code_byte   <= it.code;
      req_valid_bits  <= it.bits;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_item(it);
      items_sent++;
      if (typed) begin
         if (hit) expected_symbols.push_back('{want, 1'b1});
      end else begin
         for (k = 0; k < decoded_n; k++) expected_symbols.push_back(decoded[k]);
      end
   endtask

   // Stop sending, keep the receiver ready, and wait until every expected
   // symbol has arrived and a byte with no leaf could have finished.
   task automatic wait_idle();
      req_valid <= 1'b0;
      hold_rsp  <= 1'b1;
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      hold_rsp  <= 1'b0;
   endtask

   // Write the root register while the block is idle, then read it back.
   task automatic set_root(input logic [IDX_W-1:0] idx);
      logic [31:0] data;
      data = $urandom;
      data[IDX_W-1:0] = idx;
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ROOT_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      root_idx  = idx;
      walk_node = idx;
      root_writes++;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[IDX_W-1:0] !== idx) begin
         $error("root_node: expected %0d, actual %0d", idx, csr_prdata[IDX_W-1:0]);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Build a random code tree bottom-up, so every child is loaded before its
   // parent, and make its top node the root.
   task automatic grow_tree(input int leaves);
      int               pool[$];
      int               i;
      int               a;
      decoder_item_type it;
      for (i = 0; i < NODE_COUNT; i++) in_tree[i] = 1'b0;
      for (i = 0; i < leaves; i++) begin
         it = random_item();
         it.kind       = htwd_pkg::KIND_LOAD;
         it.leaf       = 1'b1;
         it.node_index = fresh_index();
         send_item(it, 1'b0, 1'b0, '0);
         pool.push_back(int'(it.node_index));
      end
      while (pool.size() > 1) begin
         it = random_item();
         it.kind = htwd_pkg::KIND_LOAD;
         it.leaf = 1'b0;
         a = $urandom_range(pool.size() - 1);
         it.left = IDX_W'(pool[a]);
         pool.delete(a);
         a = $urandom_range(pool.size() - 1);
         it.right = IDX_W'(pool[a]);
         pool.delete(a);
         it.node_index = fresh_index();
         send_item(it, 1'b0, 1'b0, '0);
         pool.push_back(int'(it.node_index));
      end
      set_root(IDX_W'(pool[0]));
      trees_built++;
   endtask

   initial begin
      int               r;
      int               t;
      int               k;
      int               roll;
      plan_row_type     row;
      decoder_item_type it;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed corner cases, with the sender and receiver both idling.
      gap_pct = 33;
      stall_pct <= 74;
      for (r = 0; r < 24; r++) begin
         row = plan[r];
         if (row.op == ROW_ROOT) begin
            set_root(row.index);
         end else begin
            it.kind       = (row.op == ROW_LOAD) ? htwd_pkg::KIND_LOAD : htwd_pkg::KIND_CODE;
            it.node_index = row.index;
            it.left       = row.left;
            it.right      = row.right;
            it.leaf       = row.leaf;
            it.sym        = row.sym;
            it.code       = row.code;
            it.bits       = row.bits;
            send_item(it, row.typed, row.hit, row.want);
         end
      end

      // Random trees, each followed by a stream of code bytes mixed with
      // stray node loads that keep every reachable node loaded. A stray leaf
      // may land on the root or on the node the walk stands on, so its
      // children point at loaded nodes too.
      for (t = 0; t < TREE_COUNT; t++) begin
         case (t / 2)
            0: begin
               gap_pct = 33;
               stall_pct <= 74;
            end
            1: begin
               gap_pct = 74;
               stall_pct <= 33;
            end
            default: begin
               gap_pct = 0;
               stall_pct <= 0;
            end
         endcase
         grow_tree($urandom_range(2, 12));
         for (k = 0; k < STREAM_ITEMS; k++) begin
            it = random_item();
            roll = $urandom_range(99);
            if (roll < 80) begin
               it.kind = htwd_pkg::KIND_CODE;
               if (roll < 55) it.bits = CNT_W'(CNT_MAX);
            end else if (roll < 90) begin
               it.kind  = htwd_pkg::KIND_LOAD;
               it.leaf  = 1'b1;
               it.left  = IDX_W'(loaded_nodes[$urandom_range(loaded_nodes.size() - 1)]);
               it.right = IDX_W'(loaded_nodes[$urandom_range(loaded_nodes.size() - 1)]);
            end else begin
               it.kind  = htwd_pkg::KIND_LOAD;
               it.leaf  = 1'b0;
               it.left  = IDX_W'(loaded_nodes[$urandom_range(loaded_nodes.size() - 1)]);
               it.right = IDX_W'(loaded_nodes[$urandom_range(loaded_nodes.size() - 1)]);
            end
            send_item(it, 1'b0, 1'b0, '0);
         end
      end

      wait_idle();
      $display("Decoded and checked %0d symbols from %0d transactions over %0d random trees,",
               symbols_seen, items_sent, trees_built);
      $display("with %0d root register writes and three sender/receiver idle patterns.",
               root_writes);
      if (errors == 0) begin
         $display("huffman_tree_walk_decoder_core test passed");
      end else begin
         $display("huffman_tree_walk_decoder_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: huffman_tree_walk_decoder_core.f
src/htwd_pkg.sv
src/htwd_ram.sv
src/huffman_tree_walk_decoder_core.sv
dv/huffman_tree_walk_decoder_core_test.sv
